// ===== design/utf8dec_pkg.sv =====
`timescale 1ns / 1ps

package utf8dec_pkg;

    localparam int POINT_W = 21;
    localparam int BYTE_W  = 8;

    typedef logic [1:0]         t_width_code;
    typedef logic [1:0]         t_rem_count;
    typedef logic [POINT_W-1:0] t_point;

    // Unit width and width class codes share one encoding.
    localparam t_width_code WIDTH_8  = 2'd0;
    localparam t_width_code WIDTH_16 = 2'd1;
    localparam t_width_code WIDTH_32 = 2'd2;

    // Lead byte prefixes, compared against the top bits of the byte.
    localparam logic [2:0] LEAD2_PREFIX = 3'b110;
    localparam logic [3:0] LEAD3_PREFIX = 4'b1110;
    localparam logic [4:0] LEAD4_PREFIX = 5'b11110;

    localparam int CONT_BITS  = 6;
    localparam int LEAD2_BITS = 5;
    localparam int LEAD3_BITS = 4;
    localparam int LEAD4_BITS = 3;

    localparam t_width_code UNIT_WIDTH_RESET = WIDTH_32;

    function automatic t_width_code max_class(input t_width_code a, input t_width_code b);
        max_class = (a < b) ? b : a;
    endfunction

    function automatic t_point truncate_point(input t_point cp, input t_width_code uw);
        t_point res;
        case (uw)
            WIDTH_8:  res = {{(POINT_W-8){1'b0}}, cp[7:0]};
            WIDTH_16: res = {{(POINT_W-16){1'b0}}, cp[15:0]};
            default:  res = cp;
        endcase
        truncate_point = res;
    endfunction

endpackage

// ===== design/utf8_to_codepoint_decoder_unit.sv =====
`timescale 1ns / 1ps

// UTF-8 decoder taking one byte per clock and producing one code point per completed
// one- to four-byte sequence, truncated to the configured unit width (8, 16 or 32 bits).
// A byte is decoded in the cycle of its transfer and the result lands in a single output
// register, so the sustained rate is one byte per clock; the input is ready whenever that
// register is empty or is being drained in the same cycle. Continuation bytes are masked
// to six bits without checking their top bits. An invalid lead byte, or a last byte that
// cuts a sequence short, yields a result with bad_sequence set and code point zero. The
// running width class (16 bits for two- and three-byte sequences, 32 for four-byte ones)
// accompanies each result and clears, with all decode state, after the last byte.
// Write unit_width only while no transfer is pending.
module utf8_to_codepoint_decoder_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_wr_en,
    input  logic [1:0]  i_cfg_wr_data,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [7:0]  i_byte_in,
    input  logic        i_last_byte,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [20:0] o_code_point,
    output logic        o_bad_sequence,
    output logic [1:0]  o_width_needed,
    output logic        o_end_of_string
);

    utf8dec_pkg::t_width_code r_unit_width;
    utf8dec_pkg::t_rem_count  r_bytes_rem, n_bytes_rem;
    utf8dec_pkg::t_point      r_partial, n_partial;
    utf8dec_pkg::t_width_code r_width_class, n_width_class;

    logic                     r_out_valid;
    utf8dec_pkg::t_point      r_code_point;
    logic                     r_bad;
    utf8dec_pkg::t_width_code r_width_needed;
    logic                     r_eos;

    logic                     in_fire;
    logic                     emit;
    utf8dec_pkg::t_point      emit_point;
    logic                     emit_bad;
    utf8dec_pkg::t_width_code emit_class;
    utf8dec_pkg::t_point      cont_point;
    utf8dec_pkg::t_rem_count  cont_rem;

    assign o_in_ready = !r_out_valid || i_out_ready;
    assign in_fire    = i_in_valid && o_in_ready;

    assign cont_point = {r_partial[utf8dec_pkg::POINT_W-utf8dec_pkg::CONT_BITS-1:0],
                         i_byte_in[utf8dec_pkg::CONT_BITS-1:0]};
    assign cont_rem   = r_bytes_rem - 2'd1;

    always_comb begin
        n_bytes_rem   = r_bytes_rem;
        n_partial     = r_partial;
        n_width_class = r_width_class;
        emit          = 1'b0;
        emit_point    = '0;
        emit_bad      = 1'b0;

        if (r_bytes_rem == '0) begin
            if (!i_byte_in[7]) begin
                emit       = 1'b1;
                emit_point = {{(utf8dec_pkg::POINT_W-8){1'b0}}, i_byte_in};
            end else if (i_byte_in[7:5] == utf8dec_pkg::LEAD2_PREFIX) begin
                n_partial     = {{(utf8dec_pkg::POINT_W-utf8dec_pkg::LEAD2_BITS){1'b0}},
                                 i_byte_in[utf8dec_pkg::LEAD2_BITS-1:0]};
                n_bytes_rem   = 2'd1;
                n_width_class = utf8dec_pkg::max_class(r_width_class, utf8dec_pkg::WIDTH_16);
            end else if (i_byte_in[7:4] == utf8dec_pkg::LEAD3_PREFIX) begin
                n_partial     = {{(utf8dec_pkg::POINT_W-utf8dec_pkg::LEAD3_BITS){1'b0}},
                                 i_byte_in[utf8dec_pkg::LEAD3_BITS-1:0]};
                n_bytes_rem   = 2'd2;
                n_width_class = utf8dec_pkg::max_class(r_width_class, utf8dec_pkg::WIDTH_16);
            end else if (i_byte_in[7:3] == utf8dec_pkg::LEAD4_PREFIX) begin
                n_partial     = {{(utf8dec_pkg::POINT_W-utf8dec_pkg::LEAD4_BITS){1'b0}},
                                 i_byte_in[utf8dec_pkg::LEAD4_BITS-1:0]};
                n_bytes_rem   = 2'd3;
                n_width_class = utf8dec_pkg::max_class(r_width_class, utf8dec_pkg::WIDTH_32);
            end else begin
                emit     = 1'b1;
                emit_bad = 1'b1;
            end
            // A lead byte that is also the last byte leaves a cut sequence.
            if (!emit && n_bytes_rem != '0 && i_last_byte) begin
                emit     = 1'b1;
                emit_bad = 1'b1;
            end
        end else begin
            n_partial   = cont_point;
            n_bytes_rem = cont_rem;
            if (cont_rem == '0) begin
                emit       = 1'b1;
                emit_point = cont_point;
            end else if (i_last_byte) begin
                emit     = 1'b1;
                emit_bad = 1'b1;
            end
        end

        // The reported class is the one in force before the end-of-string clear.
        emit_class = n_width_class;

        if (i_last_byte) begin
            n_bytes_rem   = '0;
            n_partial     = '0;
            n_width_class = utf8dec_pkg::WIDTH_8;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_unit_width  <= utf8dec_pkg::UNIT_WIDTH_RESET;
            r_bytes_rem   <= '0;
            r_partial     <= '0;
            r_width_class <= utf8dec_pkg::WIDTH_8;
            r_out_valid   <= 1'b0;
        end else begin
            if (i_cfg_wr_en) begin
                r_unit_width <= i_cfg_wr_data;
            end
            if (in_fire) begin
                r_bytes_rem   <= n_bytes_rem;
                r_partial     <= n_partial;
                r_width_class <= n_width_class;
                r_out_valid   <= emit;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_fire && emit) begin
            r_code_point   <= utf8dec_pkg::truncate_point(emit_point, r_unit_width);
            r_bad          <= emit_bad;
            r_width_needed <= emit_class;
            r_eos          <= i_last_byte;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_code_point    = r_code_point;
    assign o_bad_sequence  = r_bad;
    assign o_width_needed  = r_width_needed;
    assign o_end_of_string = r_eos;

    // An error result never carries a code point.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_bad_sequence) |-> (o_code_point == '0))
        else $error("error result with nonzero code point");

    // The last byte always leaves the decoder at the start of a fresh string.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_fire && i_last_byte) |=> (r_bytes_rem == '0 && r_width_class == '0
                                      && r_partial == '0))
        else $error("decode state not cleared after last byte");

    // Any open sequence has already raised the width class.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_bytes_rem != '0) |-> (r_width_class != utf8dec_pkg::WIDTH_8))
        else $error("open sequence with 8-bit width class");

    // An accepted byte that completes nothing must not leave a stale result behind.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_fire && !emit) |=> !o_out_valid)
        else $error("result valid without an emitting byte");

endmodule
